@@ rtl/lpnd_pkg.sv @@
// shared types, codes and helpers for the lp-norm vector distance unit
package lpnd_pkg;

  localparam int unsigned SAMPLE_W   = 16;
  localparam int unsigned DIST_W     = 60;
  localparam int unsigned COUNT_W    = 11;
  localparam int unsigned CFG_IDX_W  = 1;
  localparam int unsigned CFG_DATA_W = 4;

  localparam logic [CFG_IDX_W-1:0] REG_MEASURE_MODE    = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MINKOWSKI_POWER = 1'd1;

  localparam logic [3:0] MODE_MANHATTAN = 4'd0;
  localparam logic [3:0] MODE_SQ_EUCLID = 4'd1;
  localparam logic [3:0] MODE_EUCLID    = 4'd2;
  localparam logic [3:0] MODE_MINKOWSKI = 4'd3;
  localparam logic [3:0] MODE_CHEBYSHEV = 4'd4;
  localparam logic [3:0] MODE_AVG_L1_LI = 4'd5;
  localparam logic [3:0] MODE_INTERSECT = 4'd6;
  localparam logic [3:0] MODE_GOWER     = 4'd7;
  localparam logic [3:0] MODE_INNER     = 4'd8;

  localparam logic [1:0] POWER_ONE   = 2'd1;
  localparam logic [1:0] POWER_TWO   = 2'd2;
  localparam logic [1:0] POWER_THREE = 2'd3;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] x_sample;
    logic signed [SAMPLE_W-1:0] y_sample;
    logic                       last_element;
  } in_item_t;

  typedef struct packed {
    logic signed [DIST_W-1:0] distance;
    logic [COUNT_W-1:0]       element_count;
    logic                     length_overflow;
  } out_item_t;

  typedef enum logic [1:0] {
    ROOT_SQRT = 2'd0,
    ROOT_CBRT = 2'd1,
    ROOT_DIV  = 2'd2
  } root_op_e;

  typedef struct packed {
    logic     start;
    root_op_e op;
  } root_cmd_t;

  // exponent in force: minkowski power in minkowski mode (zero acts as one), else two
  function automatic logic [1:0] eff_power(input logic [3:0] mode, input logic [1:0] pow);
    logic [1:0] p;
    p = POWER_TWO;
    if (mode == MODE_MINKOWSKI) begin
      p = (pow == 2'd0) ? POWER_ONE : pow;
    end
    return p;
  endfunction

endpackage

@@ rtl/lpnd_accum.sv @@
// per-pair accumulator: shared multiplier sequenced over product, square and cube
module lpnd_accum #(
  parameter int unsigned SAMPLE_BITS = 16,
  parameter int unsigned MAX_LENGTH  = 1024,
  localparam int unsigned CW = $clog2(MAX_LENGTH + 1),
  localparam int unsigned AW = SAMPLE_BITS + CW,
  localparam int unsigned PW = (3 * SAMPLE_BITS + CW > 64) ? 64 : 3 * SAMPLE_BITS + CW,
  localparam int unsigned XW = (2 * SAMPLE_BITS + CW > 64) ? 64 : 2 * SAMPLE_BITS + CW
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    in_valid_i,
  output logic                    in_stall_o,
  input  lpnd_pkg::in_item_t      in_data_i,
  input  logic [3:0]              mode_i,
  input  logic [1:0]              power_i,
  input  logic                    fin_ack_i,
  output logic                    hold_o,
  output logic [AW-1:0]           abs_sum_o,
  output logic [PW-1:0]           pow_sum_o,
  output logic [SAMPLE_BITS-1:0]  max_o,
  output logic signed [XW-1:0]    prod_sum_o,
  output logic [CW-1:0]           count_o,
  output logic                    ovf_o
);
  import lpnd_pkg::*;

  localparam int unsigned SB = SAMPLE_BITS;
  localparam int unsigned MA = 2 * SB + 1;
  localparam int unsigned MB = SB + 1;
  localparam int unsigned MW = MA + MB;

  typedef enum logic [5:0] {
    A_IDLE = 6'b000001,
    A_MXY  = 6'b000010,
    A_MSQ  = 6'b000100,
    A_MCU  = 6'b001000,
    A_ACC  = 6'b010000,
    A_HOLD = 6'b100000
  } acc_state_e;

  acc_state_e state_q, state_d;

  logic signed [SB-1:0] x_in, y_in;
  logic signed [SB:0]   diff;
  logic [SB-1:0]        d_in;
  logic                 accept;
  logic                 full;

  logic signed [SB-1:0] x_q, y_q;
  logic [SB-1:0]        d_q;
  logic [1:0]           p_q;
  logic                 last_q;
  logic signed [MW-1:0] mul_q;
  logic signed [MA-1:0] mul_a;
  logic signed [MB-1:0] mul_b;
  logic [PW-1:0]        pw_add;

  logic [AW-1:0]        abs_sum_q;
  logic [PW-1:0]        pow_sum_q;
  logic [SB-1:0]        max_q;
  logic signed [XW-1:0] prod_sum_q;
  logic [CW-1:0]        count_q;
  logic                 ovf_q;

  assign x_in   = in_data_i.x_sample[SB-1:0];
  assign y_in   = in_data_i.y_sample[SB-1:0];
  assign diff   = (SB + 1)'(x_in) - (SB + 1)'(y_in);
  assign d_in   = diff[SB] ? SB'(-diff) : diff[SB-1:0];
  assign accept = in_valid_i && (state_q == A_IDLE);
  assign full   = (count_q == CW'(MAX_LENGTH));

  assign in_stall_o = (state_q != A_IDLE);
  assign hold_o     = (state_q == A_HOLD);
  assign abs_sum_o  = abs_sum_q;
  assign pow_sum_o  = pow_sum_q;
  assign max_o      = max_q;
  assign prod_sum_o = prod_sum_q;
  assign count_o    = count_q;
  assign ovf_o      = ovf_q;

  // operand select for the shared multiplier
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state_q)
      A_MXY: begin
        mul_a = MA'(x_q);
        mul_b = MB'(y_q);
      end
      A_MSQ: begin
        mul_a = MA'({1'b0, d_q});
        mul_b = MB'({1'b0, d_q});
      end
      A_MCU: begin
        mul_a = MA'({1'b0, mul_q[2*SB-1:0]});
        mul_b = MB'({1'b0, d_q});
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign pw_add = (p_q == POWER_ONE) ? PW'(d_q) : PW'($unsigned(mul_q));

  always_comb begin
    state_d = state_q;
    case (state_q)
      A_IDLE: begin
        if (in_valid_i) begin
          if (full) begin
            state_d = in_data_i.last_element ? A_HOLD : A_IDLE;
          end else begin
            state_d = A_MXY;
          end
        end
      end
      A_MXY:   state_d = A_MSQ;
      A_MSQ:   state_d = (p_q == POWER_THREE) ? A_MCU : A_ACC;
      A_MCU:   state_d = A_ACC;
      A_ACC:   state_d = last_q ? A_HOLD : A_IDLE;
      A_HOLD:  state_d = fin_ack_i ? A_IDLE : A_HOLD;
      default: state_d = A_IDLE;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      x_q    <= x_in;
      y_q    <= y_in;
      d_q    <= d_in;
      p_q    <= eff_power(mode_i, power_i);
      last_q <= in_data_i.last_element;
    end
    if (state_q == A_MXY || state_q == A_MSQ || state_q == A_MCU) begin
      mul_q <= MW'(mul_a * mul_b);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= A_IDLE;
      abs_sum_q  <= '0;
      pow_sum_q  <= '0;
      max_q      <= '0;
      prod_sum_q <= '0;
      count_q    <= '0;
      ovf_q      <= 1'b0;
    end else begin
      state_q <= state_d;
      if (accept && full) begin
        ovf_q <= 1'b1;
      end
      if (state_q == A_MSQ) begin
        prod_sum_q <= prod_sum_q + XW'(mul_q);
      end
      if (state_q == A_ACC) begin
        abs_sum_q <= abs_sum_q + AW'(d_q);
        pow_sum_q <= pow_sum_q + pw_add;
        count_q   <= count_q + CW'(1);
        if (d_q > max_q) begin
          max_q <= d_q;
        end
      end
      if (state_q == A_HOLD && fin_ack_i) begin
        abs_sum_q  <= '0;
        pow_sum_q  <= '0;
        max_q      <= '0;
        prod_sum_q <= '0;
        count_q    <= '0;
        ovf_q      <= 1'b0;
      end
    end
  end

endmodule

@@ rtl/lpnd_root_unit.sv @@
// shared digit-serial unit: square root, cube root and division, one digit per cycle
module lpnd_root_unit #(
  parameter int unsigned W   = 59,
  parameter int unsigned DVW = 11
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  lpnd_pkg::root_cmd_t cmd_i,
  input  logic [W-1:0]        operand_i,
  input  logic [DVW-1:0]      divisor_i,
  output logic                done_o,
  output logic [W-1:0]        result_o
);
  import lpnd_pkg::*;

  localparam int unsigned SW       = W + 2;
  localparam int unsigned EW       = W + 3;
  localparam int unsigned SQ_STEPS = (W + 1) / 2;
  localparam int unsigned CB_STEPS = (W + 2) / 3;
  localparam int unsigned DV_STEPS = W;
  localparam int unsigned SCW      = $clog2(W + 1);
  localparam int unsigned SQ_ALIGN = SW - 2 * SQ_STEPS;
  localparam int unsigned CB_ALIGN = SW - 3 * CB_STEPS;
  localparam int unsigned DV_ALIGN = SW - W;

  logic           busy_q;
  logic           done_q;
  logic [SCW-1:0] step_q;
  root_op_e       op_q;
  logic [DVW-1:0] divisor_q;
  logic [SW-1:0]  src_q, src_d;
  logic [W-1:0]   rem_q, rem_d;
  logic [W-1:0]   root_q, root_d;
  logic [W-1:0]   sq_q, sq_d;

  logic [EW-1:0]  shifted, trial, diff, y2, sq4;
  logic           ge;

  assign done_o   = done_q;
  assign result_o = root_q;

  always_comb begin
    y2      = EW'(root_q) << 1;
    sq4     = EW'(sq_q) << 2;
    shifted = '0;
    trial   = '0;
    case (op_q)
      ROOT_SQRT: begin
        shifted = EW'({rem_q, src_q[SW-1 -: 2]});
        trial   = EW'({root_q, 2'b01});
      end
      ROOT_CBRT: begin
        // 3*(2y)*(2y+1)+1 from y and y*y kept in registers
        shifted = EW'({rem_q, src_q[SW-1 -: 3]});
        trial   = (sq4 << 1) + sq4 + (y2 << 1) + y2 + EW'(1);
      end
      ROOT_DIV: begin
        shifted = EW'({rem_q, src_q[SW-1]});
        trial   = EW'(divisor_q);
      end
      default: begin
        shifted = '0;
        trial   = '0;
      end
    endcase
    ge    = (shifted >= trial);
    diff  = shifted - trial;
    rem_d = ge ? W'(diff) : W'(shifted);
    sq_d  = sq_q;
    case (op_q)
      ROOT_SQRT: begin
        root_d = {root_q[W-2:0], ge};
        src_d  = src_q << 2;
      end
      ROOT_CBRT: begin
        root_d = W'(y2 + EW'(ge));
        sq_d   = ge ? W'(sq4 + (y2 << 1) + EW'(1)) : W'(sq4);
        src_d  = src_q << 3;
      end
      ROOT_DIV: begin
        root_d = {root_q[W-2:0], ge};
        src_d  = src_q << 1;
      end
      default: begin
        root_d = root_q;
        src_d  = src_q;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      step_q <= '0;
    end else begin
      done_q <= 1'b0;
      if (cmd_i.start) begin
        busy_q <= 1'b1;
        case (cmd_i.op)
          ROOT_SQRT: step_q <= SCW'(SQ_STEPS);
          ROOT_CBRT: step_q <= SCW'(CB_STEPS);
          ROOT_DIV:  step_q <= SCW'(DV_STEPS);
          default:   step_q <= SCW'(1);
        endcase
      end else if (busy_q) begin
        step_q <= step_q - SCW'(1);
        if (step_q == SCW'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.start) begin
      op_q      <= cmd_i.op;
      divisor_q <= divisor_i;
      rem_q     <= '0;
      root_q    <= '0;
      sq_q      <= '0;
      case (cmd_i.op)
        ROOT_SQRT: src_q <= SW'(operand_i) << SQ_ALIGN;
        ROOT_CBRT: src_q <= SW'(operand_i) << CB_ALIGN;
        ROOT_DIV:  src_q <= SW'(operand_i) << DV_ALIGN;
        default:   src_q <= '0;
      endcase
    end else if (busy_q) begin
      src_q  <= src_d;
      rem_q  <= rem_d;
      root_q <= root_d;
      sq_q   <= sq_d;
    end
  end

  a_start_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.start |-> !busy_q)
    else $error("root unit started while busy");

  a_done_after_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> (!busy_q && $past(busy_q)))
    else $error("root unit done without a run");

  a_div_rem: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (busy_q && op_q == ROOT_DIV) |-> (W'(divisor_q) > rem_q))
    else $error("division remainder not below divisor");

endmodule

@@ rtl/lp_norm_vector_distance_unit.sv @@
// top level: config registers, finish sequencer, root unit and output register
// an accepted pair runs product, square, cube (exponent three only) and accumulate steps;
// a pair past max length is not accumulated and sets overflow; on the last pair the result
// is registered, or first the root unit runs (W+1)/2 steps for square root, (W+2)/3 for cube root, W for gower,
// with W = min(3*SAMPLE_BITS + clog2(MAX_LENGTH+1), 64)
// asynchronous active-low reset clears all sums and control; mode 0, power 2
module lp_norm_vector_distance_unit #(
  parameter int unsigned MAX_LENGTH  = 1024,
  parameter int unsigned SAMPLE_BITS = 16
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  lpnd_pkg::in_item_t                  in_data_i,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output lpnd_pkg::out_item_t                 out_data_o,
  input  logic                                cfg_we_i,
  input  logic [lpnd_pkg::CFG_IDX_W-1:0]      cfg_idx_i,
  input  logic [lpnd_pkg::CFG_DATA_W-1:0]     cfg_wdata_i
);
  import lpnd_pkg::*;

  localparam int unsigned CW = $clog2(MAX_LENGTH + 1);
  localparam int unsigned AW = SAMPLE_BITS + CW;
  localparam int unsigned PW = (3 * SAMPLE_BITS + CW > 64) ? 64 : 3 * SAMPLE_BITS + CW;
  localparam int unsigned XW = (2 * SAMPLE_BITS + CW > 64) ? 64 : 2 * SAMPLE_BITS + CW;

  typedef enum logic [2:0] {
    T_IDLE = 3'b001,
    T_ROOT = 3'b010,
    T_OUT  = 3'b100
  } fin_state_e;

  fin_state_e state_q, state_d;

  logic [3:0] mode_q;
  logic [1:0] pow_q;
  logic [1:0] p_eff;

  logic                    acc_hold;
  logic                    fin_ack;
  logic [AW-1:0]           acc_abs;
  logic [PW-1:0]           acc_pow;
  logic [SAMPLE_BITS-1:0]  acc_max;
  logic signed [XW-1:0]    acc_prod;
  logic [CW-1:0]           acc_count;
  logic                    acc_ovf;

  root_cmd_t      root_cmd;
  logic [PW-1:0]  root_operand;
  logic           root_done;
  logic [PW-1:0]  root_result;

  logic               needs_unit;
  logic [63:0]        direct, abs64, pow64, max64, root64;
  logic signed [63:0] prod64;
  logic [DIST_W-1:0]  res_q, res_d;
  logic               out_free;
  logic               out_valid_q, out_valid_d;
  out_item_t          out_data_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= MODE_MANHATTAN;
      pow_q  <= POWER_TWO;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_MEASURE_MODE:    mode_q <= cfg_wdata_i[3:0];
        REG_MINKOWSKI_POWER: pow_q  <= cfg_wdata_i[1:0];
        default: begin
          mode_q <= mode_q;
        end
      endcase
    end
  end

  assign p_eff = eff_power(mode_q, pow_q);

  lpnd_accum #(
    .SAMPLE_BITS(SAMPLE_BITS),
    .MAX_LENGTH (MAX_LENGTH)
  ) u_accum (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .mode_i     (mode_q),
    .power_i    (pow_q),
    .fin_ack_i  (fin_ack),
    .hold_o     (acc_hold),
    .abs_sum_o  (acc_abs),
    .pow_sum_o  (acc_pow),
    .max_o      (acc_max),
    .prod_sum_o (acc_prod),
    .count_o    (acc_count),
    .ovf_o      (acc_ovf)
  );

  assign needs_unit = (mode_q == MODE_EUCLID) || (mode_q == MODE_GOWER) ||
                      ((mode_q == MODE_MINKOWSKI) && (p_eff != POWER_ONE));

  always_comb begin
    root_cmd.start = (state_q == T_IDLE) && acc_hold && needs_unit;
    if (mode_q == MODE_GOWER) begin
      root_cmd.op = ROOT_DIV;
    end else if ((mode_q == MODE_MINKOWSKI) && (p_eff == POWER_THREE)) begin
      root_cmd.op = ROOT_CBRT;
    end else begin
      root_cmd.op = ROOT_SQRT;
    end
  end

  assign root_operand = (mode_q == MODE_GOWER) ? PW'(acc_abs) : acc_pow;

  lpnd_root_unit #(
    .W  (PW),
    .DVW(CW)
  ) u_root (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cmd_i     (root_cmd),
    .operand_i (root_operand),
    .divisor_i (acc_count),
    .done_o    (root_done),
    .result_o  (root_result)
  );

  // measures that need no root or division
  always_comb begin
    abs64  = 64'(acc_abs);
    pow64  = 64'(acc_pow);
    max64  = 64'(acc_max);
    prod64 = 64'(acc_prod);
    root64 = 64'(root_result);
    case (mode_q)
      MODE_MANHATTAN: direct = abs64;
      MODE_SQ_EUCLID: direct = pow64;
      MODE_MINKOWSKI: direct = pow64;
      MODE_CHEBYSHEV: direct = max64;
      MODE_AVG_L1_LI: direct = (abs64 + max64) >> 1;
      MODE_INTERSECT: direct = abs64 >> 1;
      MODE_INNER:     direct = prod64;
      default:        direct = '0;
    endcase
  end

  assign out_free = !out_valid_q || !out_stall_i;
  assign fin_ack  = (state_q == T_OUT) && out_free;

  always_comb begin
    state_d = state_q;
    res_d   = res_q;
    case (state_q)
      T_IDLE: begin
        if (acc_hold) begin
          if (needs_unit) begin
            state_d = T_ROOT;
          end else begin
            res_d   = direct[DIST_W-1:0];
            state_d = T_OUT;
          end
        end
      end
      T_ROOT: begin
        if (root_done) begin
          res_d   = root64[DIST_W-1:0];
          state_d = T_OUT;
        end
      end
      T_OUT: begin
        if (out_free) begin
          state_d = T_IDLE;
        end
      end
      default: state_d = T_IDLE;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (fin_ack) begin
      out_valid_d = 1'b1;
    end else if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= T_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    res_q <= res_d;
    if (fin_ack) begin
      out_data_q.distance        <= res_q;
      out_data_q.element_count   <= COUNT_W'(acc_count);
      out_data_q.length_overflow <= acc_ovf;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  a_root_done_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    root_done |-> (state_q == T_ROOT))
    else $error("root result arrived outside the root wait");

  a_ack_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fin_ack |-> acc_hold)
    else $error("accumulators released without a finished vector");

  a_out_from_finish: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == T_OUT))
    else $error("result beat without a finish step");

endmodule

@@ tb/testbench.sv @@
// self-checking testbench for the lp-norm vector distance unit
`timescale 1ns / 100ps

module testbench;
  import lpnd_pkg::*;

  localparam int IDLE_GAP = 80;

  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  in_valid = 1'b0;
  logic                  in_stall_o;
  in_item_t              in_data = '0;
  logic                  out_valid_o;
  logic                  out_stall = 1'b0;
  out_item_t             out_data_o;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_idx = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;

  // predictor state
  logic [3:0]       cur_mode = MODE_MANHATTAN;
  logic [1:0]       cur_pow = POWER_TWO;
  longint unsigned  abs_sum = 0;
  longint unsigned  pow_sum = 0;
  longint unsigned  max_abs = 0;
  longint signed    prod_sum = 0;
  int unsigned      pair_cnt = 0;
  bit               ovf_seen = 1'b0;

  out_item_t pending_results[$];
  out_item_t head_res;
  int        err_cnt = 0;
  int        items_sent = 0;
  bit        idle_on = 1'b1;
  int        stall_left = 0;

  lp_norm_vector_distance_unit dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall),
    .out_data_o  (out_data_o),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_wdata_i (cfg_wdata)
  );

  always #2 clk_i = ~clk_i;

  initial begin
    #(4_000_000);
    $display("CHECKS FAILED");
    $finish;
  end

  function automatic longint unsigned floor_root2(input longint unsigned v);
    longint unsigned r, t;
    int b;
    r = 0;
    for (b = 31; b >= 0; b--) begin
      t = r | (64'd1 << b);
      if (t * t <= v) r = t;
    end
    return r;
  endfunction

  function automatic longint unsigned floor_root3(input longint unsigned v);
    longint unsigned r, t;
    int b;
    r = 0;
    for (b = 20; b >= 0; b--) begin
      t = r | (64'd1 << b);
      if (t * t * t <= v) r = t;
    end
    return r;
  endfunction

  // exponent applied to |x-y|: the minkowski power only in minkowski mode
  function automatic logic [1:0] power_in_force();
    if (cur_mode != MODE_MINKOWSKI) return POWER_TWO;
    return (cur_pow == 2'd0) ? POWER_ONE : cur_pow;
  endfunction

  task automatic absorb_pair(input in_item_t item);
    longint signed   xs, ys, diff;
    longint unsigned d, pw, dist_val;
    out_item_t       res;
    xs = longint'($signed(item.x_sample));
    ys = longint'($signed(item.y_sample));
    if (pair_cnt >= 1024) begin
      ovf_seen = 1'b1;
    end else begin
      diff = xs - ys;
      d = (diff < 0) ? -diff : diff;
      pw = d;
      if (power_in_force() != POWER_ONE) pw = pw * d;
      if (power_in_force() == POWER_THREE) pw = pw * d;
      abs_sum += d;
      pow_sum += pw;
      if (d > max_abs) max_abs = d;
      prod_sum += xs * ys;
      pair_cnt++;
    end
    if (!item.last_element) return;
    case (cur_mode)
      MODE_MANHATTAN: dist_val = abs_sum;
      MODE_SQ_EUCLID: dist_val = pow_sum;
      MODE_EUCLID:    dist_val = floor_root2(pow_sum);
      MODE_MINKOWSKI: begin
        case (power_in_force())
          POWER_ONE: dist_val = pow_sum;
          POWER_TWO: dist_val = floor_root2(pow_sum);
          default:   dist_val = floor_root3(pow_sum);
        endcase
      end
      MODE_CHEBYSHEV: dist_val = max_abs;
      MODE_AVG_L1_LI: dist_val = (abs_sum + max_abs) >> 1;
      MODE_INTERSECT: dist_val = abs_sum >> 1;
      MODE_GOWER:     dist_val = abs_sum / pair_cnt;
      MODE_INNER:     dist_val = longint'(prod_sum);
      default:        dist_val = 0;
    endcase
    res.distance = dist_val[DIST_W-1:0];
    res.element_count = pair_cnt[COUNT_W-1:0];
    res.length_overflow = ovf_seen;
    pending_results.push_back(res);
    abs_sum = 0;
    pow_sum = 0;
    max_abs = 0;
    prod_sum = 0;
    pair_cnt = 0;
    ovf_seen = 1'b0;
  endtask

  task automatic send_pair(input logic signed [15:0] x, input logic signed [15:0] y,
                           input logic is_last);
    in_item_t item;
    if (idle_on && $urandom_range(0, 5) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 15)) @(posedge clk_i);
    end
    item.x_sample = x;
    item.y_sample = y;
    item.last_element = is_last;
    in_valid <= 1'b1;
    in_data <= item;
    do @(posedge clk_i); while (in_stall_o);
    items_sent++;
    absorb_pair(item);
  endtask

  // block idle: no beat offered, all results back, root unit finished
  task automatic wait_idle();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (IDLE_GAP) @(posedge clk_i);
  endtask

  task automatic set_regs(input bit do_mode, input logic [3:0] m,
                          input bit do_pow, input logic [3:0] p);
    if (do_mode) begin
      cfg_we <= 1'b1;
      cfg_idx <= REG_MEASURE_MODE;
      cfg_wdata <= m;
      @(posedge clk_i);
      cur_mode = m;
    end
    if (do_pow) begin
      cfg_we <= 1'b1;
      cfg_idx <= REG_MINKOWSKI_POWER;
      cfg_wdata <= p;
      @(posedge clk_i);
      cur_pow = p[1:0];
    end
    cfg_we <= 1'b0;
  endtask

  function automatic logic signed [15:0] rand_sample();
    int tmp;
    case ($urandom_range(0, 5))
      0: return 16'sh8000;
      1: return 16'sh7fff;
      2: begin
        tmp = $urandom_range(0, 16);
        return 16'(tmp - 8);
      end
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic logic [3:0] pick_mode();
    if ($urandom_range(0, 7) == 0) return 4'($urandom_range(9, 15));
    return 4'($urandom_range(0, 8));
  endfunction

  function automatic int pick_len();
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4, 5: return $urandom_range(1, 4);
      6, 7, 8:          return $urandom_range(5, 16);
      default:          return $urandom_range(17, 64);
    endcase
  endfunction

  task automatic send_random_vector(input int len);
    logic signed [15:0] x, y;
    int i;
    for (i = 0; i < len; i++) begin
      x = rand_sample();
      // close samples give small differences near root boundaries
      if ($urandom_range(0, 3) == 0) y = x ^ 16'($urandom_range(0, 15));
      else y = rand_sample();
      send_pair(x, y, i == len - 1);
    end
  endtask

  task automatic test_reset_defaults();
    send_pair(16'sd300, -16'sd200, 1'b1);
    wait_idle();
    set_regs(1'b1, MODE_MINKOWSKI, 1'b0, '0);
    send_pair(-16'sd7, 16'sd1000, 1'b1);
  endtask

  task automatic test_every_measure();
    int m;
    for (m = 0; m <= 8; m++) begin
      wait_idle();
      set_regs(1'b1, 4'(m), 1'b0, '0);
      send_pair(16'sh7fff, 16'sh8000, 1'b0);
      send_pair(16'sd5, 16'sd5, 1'b1);
    end
    // unused mode codes report zero distance
    wait_idle();
    set_regs(1'b1, 4'd9, 1'b0, '0);
    send_pair(16'sh8000, 16'sd1, 1'b1);
    wait_idle();
    set_regs(1'b1, 4'd15, 1'b0, '0);
    send_pair(16'sd123, -16'sd456, 1'b1);
  endtask

  task automatic test_power_select();
    wait_idle();
    set_regs(1'b1, MODE_MINKOWSKI, 1'b1, 4'b0100);   // masks to zero, acts as one
    send_pair(16'sd12345, -16'sd321, 1'b1);
    wait_idle();
    set_regs(1'b0, '0, 1'b1, 4'b1001);
    send_pair(16'sd12345, -16'sd321, 1'b1);
    wait_idle();
    set_regs(1'b0, '0, 1'b1, {2'b00, POWER_THREE});
    send_pair(16'sd12345, -16'sd321, 1'b1);
  endtask

  task automatic test_power_change_midvector();
    wait_idle();
    set_regs(1'b1, MODE_MINKOWSKI, 1'b1, {2'b00, POWER_THREE});
    send_pair(16'sd100, -16'sd200, 1'b0);
    send_pair(-16'sd5000, 16'sd3000, 1'b0);
    wait_idle();
    set_regs(1'b0, '0, 1'b1, {2'b00, POWER_ONE});
    send_pair(16'sd40, 16'sd41, 1'b1);
  endtask

  task automatic test_length_limit();
    int i;
    // full length with largest cubes, then two beats past the limit, the last one marked
    wait_idle();
    set_regs(1'b1, MODE_MINKOWSKI, 1'b1, {2'b00, POWER_THREE});
    for (i = 0; i < 1026; i++) begin
      if (i % 2 == 0) send_pair(16'sh7fff, 16'sh8000, i == 1025);
      else send_pair(16'sh8000, 16'sh7fff, i == 1025);
    end
  endtask

  task automatic test_random_vectors();
    int start;
    start = items_sent;
    while (items_sent - start < 240) begin
      if ($urandom_range(0, 2) == 0) begin
        wait_idle();
        set_regs($urandom_range(0, 1), pick_mode(), $urandom_range(0, 1),
                 4'($urandom_range(0, 15)));
      end
      if ($urandom_range(0, 9) == 0) idle_on = ~idle_on;
      send_random_vector(pick_len());
    end
  endtask

  task automatic test_back_to_back();
    int start;
    idle_on = 1'b0;
    wait_idle();
    set_regs(1'b1, 4'($urandom_range(0, 8)), 1'b1, 4'($urandom_range(1, 3)));
    start = items_sent;
    while (items_sent - start < 60) send_random_vector($urandom_range(1, 6));
  endtask

  // receiver side: random stall bursts
  always @(posedge clk_i) begin
    if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_stall <= 1'b1;
    end else if (idle_on && $urandom_range(0, 7) == 0) begin
      stall_left <= $urandom_range(0, 14);
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  task automatic flag_error(input string what, input logic [63:0] want,
                            input logic [63:0] got);
    err_cnt++;
    if (err_cnt <= 10) $display("mismatch %0s: expected %0h, got %0h", what, want, got);
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall) begin
      if (pending_results.size() == 0) begin
        flag_error("unexpected result beat", '0, out_data_o.distance);
      end else begin
        head_res = pending_results.pop_front();
        if (out_data_o.distance !== head_res.distance)
          flag_error("distance", head_res.distance, out_data_o.distance);
        if (out_data_o.element_count !== head_res.element_count)
          flag_error("element_count", head_res.element_count, out_data_o.element_count);
        if (out_data_o.length_overflow !== head_res.length_overflow)
          flag_error("length_overflow", head_res.length_overflow,
                     out_data_o.length_overflow);
      end
    end
  end

  initial begin
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_reset_defaults();
    test_every_measure();
    test_power_select();
    test_power_change_midvector();
    test_length_limit();
    test_random_vectors();
    test_back_to_back();
    wait_idle();
    if (pending_results.size() != 0) err_cnt++;
    if (err_cnt == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
rtl/lpnd_pkg.sv
rtl/lpnd_accum.sv
rtl/lpnd_root_unit.sv
rtl/lp_norm_vector_distance_unit.sv
tb/testbench.sv
